// File: rtl/nes_mmc2_bank_mapper_assert.svh
// Assertion macros for the MMC2-style bank mapper.
// Expects clk and arst_n in the scope of the including module.
`ifndef NES_MMC2_BANK_MAPPER_ASSERT_SVH
`define NES_MMC2_BANK_MAPPER_ASSERT_SVH

// checked only while out of reset
`define NMMC2_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// checked at every edge, reset included
`define NMMC2_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/nmmc2_pkg.sv
// Shared types and constants for the MMC2-style bank mapper.
// No dependencies; used by nmmc2_regs, nmmc2_map and the top level.
package nmmc2_pkg;

	typedef enum logic [1:0] {
		CMD_CPU_RD = 2'd0,
		CMD_CPU_WR = 2'd1,
		CMD_PPU_RD = 2'd2,
		CMD_PPU_WR = 2'd3
	} cmd_t;

	// register page, address bits [15:12] of a cpu write
	localparam logic [3:0] REG_PRG    = 4'hA;
	localparam logic [3:0] REG_MIRROR = 4'hF;

	localparam logic [2:0] WRAM_PAGE  = 3'b011;   // $6000-$7FFF
	localparam logic [2:0] REGS_FIRST = 3'b101;   // $A000 and up

	localparam logic [12:0] TAG_MASK  = 13'h1FF8;
	localparam logic [12:0] TAG_LO_FD = 13'h0FD8;
	localparam logic [12:0] TAG_LO_FE = 13'h0FE8;
	localparam logic [12:0] TAG_HI_FD = 13'h1FD8;
	localparam logic [12:0] TAG_HI_FE = 13'h1FE8;

	localparam logic [4:0] PRG_BANKS_RESET = 5'd2;

	typedef struct packed {
		logic [4:0]      prg_banks;
		logic [3:0]      prg_sel;
		logic [3:0][4:0] chr;
		logic            latch_lo;
		logic            latch_hi;
		logic            mirror;
	} state_t;

	typedef struct packed {
		logic       prg_we;
		logic [3:0] prg_val;
		logic       chr_we;
		logic [1:0] chr_idx;
		logic [4:0] chr_val;
		logic       mir_we;
		logic       mir_val;
		logic       lo_we;
		logic       lo_val;
		logic       hi_we;
		logic       hi_val;
	} upd_t;

endpackage

// File: rtl/nmmc2_regs.sv
// Mapper state: bank registers, CHR latches, mirroring, PRG size register.
// Depends on nmmc2_pkg.
module nmmc2_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [4:0]        cfg_data,
	input  logic              commit,
	input  nmmc2_pkg::upd_t   upd,
	output nmmc2_pkg::state_t st
);

	nmmc2_pkg::state_t st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.prg_banks <= nmmc2_pkg::PRG_BANKS_RESET;
			st_q.prg_sel   <= '0;
			st_q.chr       <= '0;
			st_q.latch_lo  <= 1'b0;
			st_q.latch_hi  <= 1'b0;
			st_q.mirror    <= 1'b1;
		end else begin
			if (cfg_we)
				st_q.prg_banks <= cfg_data;
			if (commit) begin
				if (upd.prg_we)
					st_q.prg_sel <= upd.prg_val;
				if (upd.chr_we)
					st_q.chr[upd.chr_idx] <= upd.chr_val;
				if (upd.mir_we)
					st_q.mirror <= upd.mir_val;
				if (upd.lo_we)
					st_q.latch_lo <= upd.lo_val;
				if (upd.hi_we)
					st_q.latch_hi <= upd.hi_val;
			end
		end
	end

	assign st = st_q;

endmodule

// File: rtl/nmmc2_map.sv
// Combinational decode of one bus access: mapped offset, hit, state updates.
// Depends on nmmc2_pkg.
module nmmc2_map (
	input  logic [1:0]        command,
	input  logic [15:0]       address,
	input  logic [7:0]        write_data,
	input  nmmc2_pkg::state_t st,
	output logic [17:0]       mapped,
	output logic              hit,
	output logic              mirror,
	output nmmc2_pkg::upd_t   upd
);

	nmmc2_pkg::cmd_t cmd;
	logic [4:0]      twice;
	logic [4:0]      prg_bank;
	logic [4:0]      chr_bank;
	logic [12:0]     tag;

	assign cmd   = nmmc2_pkg::cmd_t'(command);
	assign twice = {st.prg_banks[3:0], 1'b0};   // 2n mod 32
	assign tag   = address[12:0] & nmmc2_pkg::TAG_MASK;

	// last three 8 KB banks wrap in 5 bits
	always_comb begin
		unique case (address[14:13])
			2'b00:   prg_bank = {1'b0, st.prg_sel};
			2'b01:   prg_bank = twice - 5'd3;
			2'b10:   prg_bank = twice - 5'd2;
			default: prg_bank = twice - 5'd1;
		endcase
	end

	assign chr_bank = address[12] ? st.chr[{1'b1, st.latch_hi}] : st.chr[{1'b0, st.latch_lo}];

	always_comb begin
		upd    = '0;
		mapped = '0;
		hit    = 1'b0;
		unique case (cmd)
			nmmc2_pkg::CMD_CPU_RD, nmmc2_pkg::CMD_CPU_WR: begin
				if (address[15:13] == nmmc2_pkg::WRAM_PAGE) begin
					mapped = {5'd0, address[12:0]};
					hit    = 1'b1;
				end else if (cmd == nmmc2_pkg::CMD_CPU_RD && address[15]) begin
					mapped = {prg_bank, address[12:0]};
					hit    = 1'b1;
				end else if (cmd == nmmc2_pkg::CMD_CPU_WR
						&& address[15:13] >= nmmc2_pkg::REGS_FIRST) begin
					unique case (address[15:12])
						nmmc2_pkg::REG_PRG: begin
							upd.prg_we  = 1'b1;
							upd.prg_val = write_data[3:0];
						end
						nmmc2_pkg::REG_MIRROR: begin
							upd.mir_we  = 1'b1;
							upd.mir_val = write_data[0];
						end
						default: begin
							// $B000..$E000 -> chr regs 0..3
							upd.chr_we  = 1'b1;
							upd.chr_idx = address[13:12] + 2'd1;
							upd.chr_val = write_data[4:0];
						end
					endcase
				end
			end
			nmmc2_pkg::CMD_PPU_RD: begin
				if (address[15:13] == 3'b000) begin
					mapped = {1'b0, chr_bank, address[11:0]};
					hit    = 1'b1;
					if (tag == nmmc2_pkg::TAG_LO_FD) begin
						upd.lo_we  = 1'b1;
						upd.lo_val = 1'b0;
					end else if (tag == nmmc2_pkg::TAG_LO_FE) begin
						upd.lo_we  = 1'b1;
						upd.lo_val = 1'b1;
					end else if (tag == nmmc2_pkg::TAG_HI_FD) begin
						upd.hi_we  = 1'b1;
						upd.hi_val = 1'b0;
					end else if (tag == nmmc2_pkg::TAG_HI_FE) begin
						upd.hi_we  = 1'b1;
						upd.hi_val = 1'b1;
					end
				end
			end
			default: ;   // ppu writes: no hit, no change
		endcase
	end

	// mirroring as it stands after this access
	assign mirror = upd.mir_we ? upd.mir_val : st.mirror;

endmodule

// File: rtl/nes_mmc2_bank_mapper.sv
// Top level of the MMC2-style bank mapper: input stage, decode, result register.
// Depends on nmmc2_pkg, nmmc2_regs, nmmc2_map and nes_mmc2_bank_mapper_assert.svh.
//
// Usage:
//   Bus accesses enter on in_valid/in_ready with command, address and
//   write_data. Each beat yields exactly one result beat on out_valid/out_ready
//   carrying mapped_address, hit and mirror_horizontal (mirroring after it).
//   A beat is taken into the input stage, decoded against the current bank
//   and latch state, and lands in the result register once that register
//   is free to take it. One access is decoded per cycle while the receiver
//   is not stalling; the CHR latch and bank registers update in the same
//   cycle as the decode and feed the very next access.
//   When the receiver stalls, the result register holds and the input stage
//   holds one more beat; in_ready drops only when both are full.
//   cfg_valid/cfg_ready/cfg_data loads the number of 16 KB PRG banks; the port
//   is always ready; write it only while no access is in flight (not enforced).
//   Reset (arst_n low) clears both stages and sets PRG banks to 2, all bank
//   registers and latches to zero and mirroring to horizontal.
module nes_mmc2_bank_mapper (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [15:0] address,
	input  logic [7:0]  write_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [17:0] mapped_address,
	output logic        hit,
	output logic        mirror_horizontal
);

	`include "nes_mmc2_bank_mapper_assert.svh"

	logic        valid_s1;
	logic [1:0]  command_s1;
	logic [15:0] address_s1;
	logic [7:0]  data_s1;
	logic        advance;

	logic        out_valid_q;
	logic [17:0] mapped_q;
	logic        hit_q;
	logic        mirror_q;

	nmmc2_pkg::state_t st;
	nmmc2_pkg::upd_t   upd;
	logic [17:0]       mapped_c;
	logic              hit_c;
	logic              mirror_c;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			command_s1 <= command;
			address_s1 <= address;
			data_s1    <= write_data;
		end
	end

	nmmc2_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.commit   (advance),
		.upd      (upd),
		.st       (st)
	);

	nmmc2_map u_map (
		.command    (command_s1),
		.address    (address_s1),
		.write_data (data_s1),
		.st         (st),
		.mapped     (mapped_c),
		.hit        (hit_c),
		.mirror     (mirror_c),
		.upd        (upd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			mapped_q <= mapped_c;
			hit_q    <= hit_c;
			mirror_q <= mirror_c;
		end
	end

	assign out_valid         = out_valid_q;
	assign mapped_address    = mapped_q;
	assign hit               = hit_q;
	assign mirror_horizontal = mirror_q;

	`NMMC2_ASSERT(a_decode_loads_result, advance |=> out_valid_q,
		"decoded beat did not reach result register")
	`NMMC2_ASSERT(a_held_beat_kept,
		valid_s1 && !advance |=> valid_s1 && $stable(address_s1) && $stable(command_s1),
		"input stage lost a stalled beat")
	`NMMC2_ASSERT(a_miss_is_zero, out_valid_q && !hit_q |-> mapped_q == 18'd0,
		"miss with nonzero mapped offset")
	`NMMC2_ASSERT(a_reg_write_no_hit,
		advance && command_s1 == nmmc2_pkg::CMD_CPU_WR
			&& address_s1[15:13] != nmmc2_pkg::WRAM_PAGE |=> !hit_q,
		"cpu write outside work RAM reported a hit")
	`NMMC2_ASSERT_ALWAYS(a_reset_empty, !arst_n |=> !valid_s1 && !out_valid_q,
		"pipeline not empty in reset")

endmodule

// File: tb/tb.sv
// Self-checking testbench for nes_mmc2_bank_mapper: directed table, then random bus accesses.
// Uses nmmc2_pkg for command codes and tag constants; models the mapper state on its own.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ROWS = 26;
	localparam int PHASE_ACCESSES = 280;
	localparam int HOLD_CYCLES = 60;
	localparam logic [3:0] CHR_PAGE_FIRST = 4'hB;

	typedef struct packed {
		logic [17:0] offset;
		logic        hit;
		logic        mirror_h;
	} map_result_t;

	typedef struct packed {
		nmmc2_pkg::cmd_t cmd;
		logic [15:0]     addr;
		logic [7:0]      data;
		bit              pinned;
		map_result_t     want;
	} access_row_t;

	// reset state: prg page 0, chr pages 0, latches 0, horizontal mirroring, 2 banks.
	// Rows with pinned=1 carry their result typed in; the rest use the predictor.
	access_row_t dir_rows [ROWS] = '{
		'{nmmc2_pkg::CMD_CPU_RD, 16'h0000, 8'h00, 1'b1, '{18'h00000, 1'b0, 1'b1}},
		'{nmmc2_pkg::CMD_CPU_RD, 16'h5FFF, 8'hFF, 1'b1, '{18'h00000, 1'b0, 1'b1}},
		'{nmmc2_pkg::CMD_CPU_RD, 16'h6000, 8'h00, 1'b1, '{18'h00000, 1'b1, 1'b1}},
		'{nmmc2_pkg::CMD_CPU_WR, 16'h7FFF, 8'hFF, 1'b1, '{18'h01FFF, 1'b1, 1'b1}},
		'{nmmc2_pkg::CMD_CPU_RD, 16'h8000, 8'h00, 1'b1, '{18'h00000, 1'b1, 1'b1}},
		'{nmmc2_pkg::CMD_CPU_RD, 16'hFFFF, 8'h00, 1'b1, '{18'h07FFF, 1'b1, 1'b1}},
		'{nmmc2_pkg::CMD_CPU_RD, 16'hA000, 8'h00, 1'b1, '{18'h02000, 1'b1, 1'b1}},
		'{nmmc2_pkg::CMD_CPU_RD, 16'hC000, 8'h00, 1'b1, '{18'h04000, 1'b1, 1'b1}},
		'{nmmc2_pkg::CMD_CPU_WR, 16'h8000, 8'hFF, 1'b1, '{18'h00000, 1'b0, 1'b1}},
		'{nmmc2_pkg::CMD_CPU_WR, 16'hA000, 8'hFF, 1'b1, '{18'h00000, 1'b0, 1'b1}},
		'{nmmc2_pkg::CMD_CPU_RD, 16'h9FFF, 8'h00, 1'b1, '{18'h1FFFF, 1'b1, 1'b1}},
		'{nmmc2_pkg::CMD_CPU_WR, 16'hB000, 8'h1F, 1'b1, '{18'h00000, 1'b0, 1'b1}},
		'{nmmc2_pkg::CMD_CPU_WR, 16'hCFFF, 8'h01, 1'b0, '0},
		'{nmmc2_pkg::CMD_CPU_WR, 16'hD123, 8'h0A, 1'b0, '0},
		'{nmmc2_pkg::CMD_CPU_WR, 16'hEFFF, 8'hFF, 1'b0, '0},
		'{nmmc2_pkg::CMD_PPU_RD, 16'h0000, 8'h00, 1'b1, '{18'h1F000, 1'b1, 1'b1}},
		'{nmmc2_pkg::CMD_PPU_RD, 16'h0FE8, 8'h00, 1'b0, '0},
		'{nmmc2_pkg::CMD_PPU_RD, 16'h0FFF, 8'h00, 1'b0, '0},
		'{nmmc2_pkg::CMD_PPU_RD, 16'h0FDF, 8'h00, 1'b0, '0},
		'{nmmc2_pkg::CMD_PPU_RD, 16'h1FEF, 8'h00, 1'b0, '0},
		'{nmmc2_pkg::CMD_PPU_RD, 16'h1000, 8'h00, 1'b0, '0},
		'{nmmc2_pkg::CMD_PPU_RD, 16'h1FD8, 8'h00, 1'b0, '0},
		'{nmmc2_pkg::CMD_PPU_RD, 16'h2000, 8'h00, 1'b1, '{18'h00000, 1'b0, 1'b1}},
		'{nmmc2_pkg::CMD_PPU_WR, 16'h0FE8, 8'hAA, 1'b1, '{18'h00000, 1'b0, 1'b1}},
		'{nmmc2_pkg::CMD_CPU_WR, 16'hF000, 8'h00, 1'b1, '{18'h00000, 1'b0, 1'b0}},
		'{nmmc2_pkg::CMD_CPU_WR, 16'hFFFF, 8'h01, 1'b1, '{18'h00000, 1'b0, 1'b1}}
	};

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [4:0]  cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  command;
	logic [15:0] address;
	logic [7:0]  write_data;
	logic        out_valid;
	logic        out_ready;
	logic [17:0] mapped_address;
	logic        hit;
	logic        mirror_horizontal;

	// predicted mapper state
	logic [4:0]      bank_count;
	logic [3:0]      prg_page;
	logic [4:0]      chr_page [4];
	logic            latch_lo;
	logic            latch_hi;
	logic            mirror_h;

	map_result_t expected_maps [$];
	map_result_t pin_result;
	bit          pin_valid;
	int          errors;
	int          snd_idle_pct;
	int          rcv_idle_pct;
	int          hold_requests;
	int          hold_served;
	int          hold_left;

	nes_mmc2_bank_mapper dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.command           (command),
		.address           (address),
		.write_data        (write_data),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.mapped_address    (mapped_address),
		.hit               (hit),
		.mirror_horizontal (mirror_horizontal)
	);

	always #2 clk = ~clk;

	function automatic map_result_t map_access(nmmc2_pkg::cmd_t c, logic [15:0] a,
			logic [7:0] d);
		map_result_t res;
		logic [4:0]  page;
		logic [4:0]  twice;
		logic [12:0] tag;
		res = '0;
		page = '0;
		twice = {bank_count[3:0], 1'b0};
		tag = a[12:0] & nmmc2_pkg::TAG_MASK;
		case (c)
			nmmc2_pkg::CMD_CPU_RD, nmmc2_pkg::CMD_CPU_WR: begin
				if (a[15:13] == nmmc2_pkg::WRAM_PAGE) begin
					res.offset = {5'd0, a[12:0]};
					res.hit = 1'b1;
				end else if (c == nmmc2_pkg::CMD_CPU_RD && a[15]) begin
					// upper three windows sit on the last banks, 5-bit wrap
					case (a[14:13])
						2'd0: page = {1'b0, prg_page};
						2'd1: page = twice - 5'd3;
						2'd2: page = twice - 5'd2;
						default: page = twice - 5'd1;
					endcase
					res.offset = {page, a[12:0]};
					res.hit = 1'b1;
				end else if (c == nmmc2_pkg::CMD_CPU_WR
						&& a[15:13] >= nmmc2_pkg::REGS_FIRST) begin
					if (a[15:12] == nmmc2_pkg::REG_PRG)
						prg_page = d[3:0];
					else if (a[15:12] == nmmc2_pkg::REG_MIRROR)
						mirror_h = d[0];
					else
						chr_page[2'(a[15:12] - CHR_PAGE_FIRST)] = d[4:0];
				end
			end
			nmmc2_pkg::CMD_PPU_RD: begin
				if (a[15:13] == 3'd0) begin
					page = a[12] ? chr_page[{1'b1, latch_hi}] : chr_page[{1'b0, latch_lo}];
					res.offset = {1'b0, page, a[11:0]};
					res.hit = 1'b1;
					// latch flips only after the fetch that hit the tag
					if (tag == nmmc2_pkg::TAG_LO_FD)
						latch_lo = 1'b0;
					else if (tag == nmmc2_pkg::TAG_LO_FE)
						latch_lo = 1'b1;
					else if (tag == nmmc2_pkg::TAG_HI_FD)
						latch_hi = 1'b0;
					else if (tag == nmmc2_pkg::TAG_HI_FE)
						latch_hi = 1'b1;
				end
			end
			default: ;
		endcase
		res.mirror_h = mirror_h;
		return res;
	endfunction

	// result checking first, then prediction of the beat accepted at this edge
	always @(posedge clk) begin
		map_result_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_maps.size() == 0) begin
					$error("result beat with no access outstanding");
					errors++;
				end else begin
					want = expected_maps.pop_front();
					if (mapped_address !== want.offset) begin
						$error("mapped_address expected %h got %h", want.offset, mapped_address);
						errors++;
					end
					if (hit !== want.hit) begin
						$error("hit expected %b got %b", want.hit, hit);
						errors++;
					end
					if (mirror_horizontal !== want.mirror_h) begin
						$error("mirror_horizontal expected %b got %b", want.mirror_h,
							mirror_horizontal);
						errors++;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				bank_count = cfg_data;
			if (in_valid && in_ready) begin
				want = map_access(nmmc2_pkg::cmd_t'(command), address, write_data);
				if (pin_valid)
					want = pin_result;
				expected_maps.push_back(want);
			end
		end
	end

	// receiver: random stalls, plus long hold-offs on request
	always @(negedge clk) begin
		if (hold_served != hold_requests) begin
			hold_left = HOLD_CYCLES;
			hold_served = hold_requests;
		end
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else begin
			out_ready <= ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	// called at a falling edge; returns at the falling edge after the beat is taken
	task automatic drive_access(input nmmc2_pkg::cmd_t c, input logic [15:0] a,
			input logic [7:0] d, input bit pinned, input map_result_t fixed);
		while ($urandom_range(99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		pin_valid = pinned;
		pin_result = fixed;
		in_valid <= 1'b1;
		command <= c;
		address <= a;
		write_data <= d;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		int              p;
		int              i;
		int              r;
		int              mode;
		nmmc2_pkg::cmd_t c;
		logic [15:0]     a;
		logic [7:0]      d;
		logic [4:0]      bank_plan [7];
		logic [12:0]     tags [4];
		bank_plan = '{5'd2, 5'd16, 5'd3, 5'd15, 5'd9, 5'd2, 5'd2};
		bank_plan[5] = 5'($urandom_range(2, 16));
		tags = '{nmmc2_pkg::TAG_LO_FD, nmmc2_pkg::TAG_LO_FE, nmmc2_pkg::TAG_HI_FD,
			nmmc2_pkg::TAG_HI_FE};
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		command = nmmc2_pkg::CMD_CPU_RD;
		address = '0;
		write_data = '0;
		out_ready = 1'b0;
		pin_valid = 1'b0;
		pin_result = '0;
		errors = 0;
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		hold_requests = 0;
		hold_served = 0;
		hold_left = 0;
		bank_count = nmmc2_pkg::PRG_BANKS_RESET;
		prg_page = '0;
		for (i = 0; i < 4; i++)
			chr_page[i] = '0;
		latch_lo = 1'b0;
		latch_hi = 1'b0;
		mirror_h = 1'b1;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// phase 0 is the directed table, the rest are random
		for (p = 0; p < 7; p++) begin
			in_valid <= 1'b0;
			while (expected_maps.size() != 0)
				@(negedge clk);
			cfg_valid <= 1'b1;
			cfg_data <= bank_plan[p];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			@(negedge clk);
			cfg_valid <= 1'b0;

			mode = (p == 0) ? 0 : (p - 1) / 2;
			snd_idle_pct = (mode == 0) ? 32 : (mode == 1) ? 51 : 0;
			rcv_idle_pct = (mode == 0) ? 51 : (mode == 1) ? 32 : 0;

			if (p == 0) begin
				for (i = 0; i < ROWS; i++)
					drive_access(dir_rows[i].cmd, dir_rows[i].addr, dir_rows[i].data,
						dir_rows[i].pinned, dir_rows[i].want);
			end else begin
				for (i = 0; i < PHASE_ACCESSES; i++) begin
					if (i == 100 && (p == 3 || p == 5))
						hold_requests++;
					r = $urandom_range(99);
					a = 16'($urandom);
					d = 8'($urandom);
					if (r < 25) begin
						c = nmmc2_pkg::CMD_CPU_RD;
						if ($urandom_range(1))
							a = 16'($urandom_range(16'h6000, 16'hFFFF));
					end else if (r < 45) begin
						c = nmmc2_pkg::CMD_CPU_WR;
						if ($urandom_range(9) < 6)
							a = 16'($urandom_range(16'hA000, 16'hFFFF));
					end else if (r < 90) begin
						c = nmmc2_pkg::CMD_PPU_RD;
						if ($urandom_range(9) != 0)
							a[15:13] = 3'd0;
						if ($urandom_range(9) < 3)
							a[12:0] = tags[$urandom_range(3)] | 13'($urandom_range(7));
					end else begin
						c = nmmc2_pkg::CMD_PPU_WR;
					end
					drive_access(c, a, d, 1'b0, '0);
				end
			end
		end

		in_valid <= 1'b0;
		pin_valid = 1'b0;
		while (expected_maps.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
